/* src/json_key_uint_extractor_assert.svh */
// Assertion macros for the key value extractor, empty when synthesized.
`ifndef JSON_KEY_UINT_EXTRACTOR_ASSERT_SVH
`define JSON_KEY_UINT_EXTRACTOR_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define JKUE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every clock edge outside reset.
`define JKUE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JKUE_ASSERT_NOW(label, ante, cons, msg)
`define JKUE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* src/jkue_pkg.sv */
// Package with the types, character constants and key matcher of the extractor.
package jkue_pkg;

  localparam int ValueWidth = 64;
  localparam int KeyLen     = 6;
  localparam int QueueDepth = 3;

  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChLBrack  = 8'h5B;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChLowerE  = 8'h65;
  localparam logic [7:0] ChUpperE  = 8'h45;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;

  localparam logic KindValue  = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_WAIT   = 6'b000001,
    PH_FAILED = 6'b000010,
    PH_SEARCH = 6'b000100,
    PH_COLON  = 6'b001000,
    PH_VALUE  = 6'b010000,
    PH_DIGITS = 6'b100000
  } phase_t;

  typedef struct packed {
    logic                  kind;
    logic [ValueWidth-1:0] value;
    logic                  doc_ok;
    logic                  is_final;
  } result_t;

  typedef struct packed {
    logic       done;
    logic [2:0] count;
  } seek_t;

  // Characters of the quoted key, quotes included.
  function automatic logic [7:0] key_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = ChQuote;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h66;
      3'd3:    c = 8'h69;
      3'd4:    c = 8'h64;
      3'd5:    c = ChQuote;
      default: c = ChQuote;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == ChSpace) || (b >= ChTab && b <= ChCr);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

  // One step of the key matcher; a mismatch restarts on an opening quote.
  function automatic seek_t seek_key(input logic [7:0] b, input logic [2:0] count);
    seek_t      s;
    logic [2:0] k;
    k = (count >= 3'(KeyLen)) ? 3'd0 : count;
    s.done  = 1'b0;
    s.count = 3'd0;
    if (b == key_char(k)) begin
      if (k == 3'(KeyLen - 1)) begin
        s.done = 1'b1;
      end else begin
        s.count = k + 3'd1;
      end
    end else if (b == ChQuote) begin
      s.count = 3'd1;
    end
    return s;
  endfunction

endpackage

/* src/json_key_uint_extractor.sv */
// Streaming extractor of unsigned numbers that follow the quoted key "afid".
//
//   channel | direction | handshake          | payload
//   in      | to block  | in_valid/in_stall  | text_byte, end_of_text
//   out     | from block| out_valid/out_stall| result_kind, extracted_value,
//           |           |                    | document_ok, final_result
//
// One byte beat is taken per cycle while in_stall is low; its results are queued in the same edge.
// A byte yields at most two results (only the last byte can yield two), so the
// three-entry result queue sets the rate: input is stalled while it holds two
// or more results, and the last byte of a document can fill it to three.
// Reset is synchronous; it clears the parser state and empties the queue.
// Stalls on the output hold the queue head steady and back up into in_stall.
`include "json_key_uint_extractor_assert.svh"

module json_key_uint_extractor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      text_byte,
  input  logic                            end_of_text,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            result_kind,
  output logic [jkue_pkg::ValueWidth-1:0] extracted_value,
  output logic                            document_ok,
  output logic                            final_result
);
  import jkue_pkg::*;

  phase_t                phase, phase_next;
  logic [2:0]            key_cnt, key_cnt_next;
  logic [ValueWidth-1:0] acc, acc_next;
  logic                  header, header_next;

  result_t               queue [QueueDepth];
  result_t               queue_next [QueueDepth];
  logic [1:0]            cnt, cnt_next;

  logic                  accept, pop;
  result_t               res0, res1;
  logic [1:0]            n_res;
  logic [1:0]            base;
  seek_t                 seek;
  logic [ValueWidth-1:0] acc_times_ten;
  logic [ValueWidth-1:0] digit_ext;

  assign accept = in_valid & ~in_stall;
  assign pop    = out_valid & ~out_stall;

  // Room for the two results a byte can cause.
  assign in_stall  = (cnt > 2'd1);
  assign out_valid = (cnt != 2'd0);

  assign result_kind     = queue[0].kind;
  assign extracted_value = queue[0].value;
  assign document_ok     = queue[0].doc_ok;
  assign final_result    = queue[0].is_final;

  // Decimal accumulation: acc * 10 as two shifts, plus the digit.
  assign acc_times_ten = {acc[ValueWidth-4:0], 3'b000} + {acc[ValueWidth-2:0], 1'b0};
  assign digit_ext     = {{(ValueWidth-4){1'b0}}, text_byte[3:0]};

  // Parser step for the incoming byte and the results it causes.
  always_comb begin
    phase_next   = phase;
    key_cnt_next = key_cnt;
    acc_next     = acc;
    header_next  = header;
    n_res        = 2'd0;
    res0         = '{kind: KindValue, value: acc, doc_ok: 1'b1, is_final: 1'b0};
    res1         = '{kind: KindStatus, value: '0, doc_ok: 1'b0, is_final: 1'b1};
    seek         = seek_key(text_byte, key_cnt);

    case (phase)
      PH_WAIT: begin
        if (text_byte == ChLBrack) begin
          header_next  = 1'b1;
          phase_next   = PH_SEARCH;
          key_cnt_next = 3'd0;
        end else if (!is_space(text_byte)) begin
          phase_next = PH_FAILED;
        end
      end
      PH_SEARCH: begin
        key_cnt_next = seek.count;
        if (seek.done) phase_next = PH_COLON;
      end
      PH_COLON: begin
        if (text_byte == ChColon) begin
          phase_next = PH_VALUE;
        end else if (!is_space(text_byte)) begin
          key_cnt_next = seek.count;
          phase_next   = seek.done ? PH_COLON : PH_SEARCH;
        end
      end
      PH_VALUE: begin
        if (is_digit(text_byte)) begin
          acc_next   = digit_ext;
          phase_next = PH_DIGITS;
        end else if (!is_space(text_byte)) begin
          key_cnt_next = seek.count;
          phase_next   = seek.done ? PH_COLON : PH_SEARCH;
        end
      end
      PH_DIGITS: begin
        if (is_digit(text_byte)) begin
          acc_next = acc_times_ten + digit_ext;
        end else begin
          // A run followed by a fraction or exponent mark is dropped.
          if (text_byte != ChDot && text_byte != ChLowerE && text_byte != ChUpperE) begin
            n_res = 2'd1;
          end
          acc_next = '0;
          seek     = seek_key(text_byte, 3'd0);
          key_cnt_next = seek.count;
          phase_next   = seek.done ? PH_COLON : PH_SEARCH;
        end
      end
      PH_FAILED: begin
      end
      default: begin
        phase_next = PH_FAILED;
      end
    endcase

    // Last byte: flush an open digit run, add the status, return to reset.
    if (end_of_text) begin
      if (phase_next == PH_DIGITS) begin
        res0.value = acc_next;
        n_res      = 2'd1;
      end
      res1.doc_ok = header_next;
      if (n_res == 2'd1) begin
        n_res = 2'd2;
      end else begin
        res0  = res1;
        n_res = 2'd1;
      end
      phase_next   = PH_WAIT;
      key_cnt_next = 3'd0;
      acc_next     = '0;
      header_next  = 1'b0;
    end else begin
      res0.is_final = 1'b1;
    end
  end

  // Result queue: head at entry zero, shifts on each output beat.
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      queue_next[i] = queue[i];
    end
    if (pop) begin
      for (int i = 0; i < QueueDepth - 1; i++) begin
        queue_next[i] = queue[i+1];
      end
    end
    base     = cnt - {1'b0, pop};
    cnt_next = base;
    if (accept) begin
      if (n_res != 2'd0) queue_next[base] = res0;
      if (n_res == 2'd2) queue_next[2'(base + 2'd1)] = res1;
      cnt_next = base + n_res;
    end
  end

  // Parser state and queue fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_WAIT;
      key_cnt <= 3'd0;
      acc     <= '0;
      header  <= 1'b0;
      cnt     <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        phase   <= phase_next;
        key_cnt <= key_cnt_next;
        acc     <= acc_next;
        header  <= header_next;
      end
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QueueDepth; i++) begin
      queue[i] <= queue_next[i];
    end
  end

  `JKUE_ASSERT_NOW(a_status_is_final, out_valid && result_kind == KindStatus, final_result, "status beat is not the final result of its byte")
  `JKUE_ASSERT_NOW(a_status_no_value, out_valid && result_kind == KindStatus, extracted_value == '0, "status beat carries a nonzero value")
  `JKUE_ASSERT_NOW(a_value_doc_ok, out_valid && result_kind == KindValue, document_ok, "value beat outside a good document")
  `JKUE_ASSERT_NEXT(a_end_resets, accept && end_of_text, phase == PH_WAIT && acc == '0 && !header, "parser not back at reset after last byte")

endmodule
